>>> rtl/ntc_pkg.sv
// ---------------------------------------------------------------------------
// ntc_pkg
// Shared widths, constants, register indexes and the ln table builder
// for the thermistor temperature pipeline.
// ---------------------------------------------------------------------------
package ntc_pkg;

   // default size of the ln(1+f) table, as log2 of its intervals
   localparam int LN_TABLE_BITS_DEF = 8;

   // resistance in Q.8 ohm, unsigned
   localparam int R_W  = 46;
   // natural log in Q32
   localparam int LN_W = 39;
   // reciprocal temperature quotients
   localparam int Q_W  = 48;
   // final temperature division
   localparam int T_W  = 49;

   localparam logic [31:0]  LN2_Q32    = 32'd2977044472;
   localparam logic [47:0]  INV_NUM    = 48'd100 << 40;
   localparam logic [18:0]  TEMP_MAX   = 19'd200000;
   localparam logic [18:0]  KELVIN_OFS = 19'd27315;
   localparam logic [48:0]  TC_MAX     = 49'd227315;

   // register reset values
   localparam logic [12:0] SUPPLY_RST = 13'd3300;
   localparam logic [19:0] SERIES_RST = 20'd10000;
   localparam logic [13:0] BETA_RST   = 14'd3950;
   localparam logic [19:0] RREF_RST   = 20'd10000;
   localparam logic [15:0] T0_RST     = 16'd29815;

   typedef enum logic [2:0] {
      CSR_SUPPLY = 3'd0,
      CSR_SERIES = 3'd1,
      CSR_BETA   = 3'd2,
      CSR_RREF   = 3'd3,
      CSR_T0     = 3'd4
   } csr_index_type;

   // ln(1+f) in Q32 from z = f/(2+f), by 2*atanh(z) series
   function automatic logic [31:0] atanh_ln(input logic [63:0] z);
      logic [63:0] z2;
      logic [63:0] term;
      logic [63:0] sum;
      z2   = (z * z) >> 32;
      term = z;
      sum  = '0;
      for (int k = 0; k < 20; k++) begin
         sum  = sum + term / 64'(2 * k + 1);
         term = (term * z2) >> 32;
      end
      return 32'(sum << 1);
   endfunction

endpackage

>>> rtl/ntc_div.sv
// ---------------------------------------------------------------------------
// ntc_div
// Pipelined restoring divider, one quotient bit per stage, with a
// sideband payload that travels alongside each item.
// ---------------------------------------------------------------------------
module ntc_div #(
   parameter int N  = 46,
   parameter int D  = 17,
   parameter int PW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [N-1:0]  in_num,
   input  logic [D-1:0]  in_den,
   input  logic [PW-1:0] in_pl,
   output logic          out_valid,
   output logic [N-1:0]  out_quo,
   output logic [PW-1:0] out_pl
);

   logic [D-1:0]  rem_ff  [N];
   logic [N-1:0]  work_ff [N];
   logic [D-1:0]  den_ff  [N];
   logic [PW-1:0] pl_ff   [N];
   logic          v_ff    [N];

   for (genvar j = 0; j < N; j++) begin : g_stage
      logic [D-1:0]  rem_p;
      logic [N-1:0]  work_p;
      logic [D-1:0]  den_p;
      logic [PW-1:0] pl_p;
      logic          v_p;
      logic [D:0]    trial;
      logic [D:0]    diff;
      logic          ge;
      logic [D-1:0]  rem_in;
      logic [N-1:0]  work_in;

      if (j == 0) begin : g_first
         assign rem_p  = '0;
         assign work_p = in_num;
         assign den_p  = in_den;
         assign pl_p   = in_pl;
         assign v_p    = in_valid;
      end else begin : g_next
         assign rem_p  = rem_ff[j-1];
         assign work_p = work_ff[j-1];
         assign den_p  = den_ff[j-1];
         assign pl_p   = pl_ff[j-1];
         assign v_p    = v_ff[j-1];
      end

      // trial subtract of the shifted remainder
      always_comb begin
         trial   = {rem_p, work_p[N-1]};
         diff    = trial - {1'b0, den_p};
         ge      = (trial >= {1'b0, den_p});
         rem_in  = ge ? diff[D-1:0] : trial[D-1:0];
         work_in = {work_p[N-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else begin
            v_ff[j] <= v_p;
         end
         rem_ff[j]  <= rem_in;
         work_ff[j] <= work_in;
         den_ff[j]  <= den_p;
         pl_ff[j]   <= pl_p;
      end
   end

   assign out_valid = v_ff[N-1];
   assign out_quo   = work_ff[N-1];
   assign out_pl    = pl_ff[N-1];

endmodule

>>> rtl/ntc_ln.sv
// ---------------------------------------------------------------------------
// ntc_ln
// Pipelined natural log in Q32: staged leading-one normalize, table
// lookup of ln(1+f) and linear interpolation.
// ---------------------------------------------------------------------------
module ntc_ln #(
   parameter int LN_TABLE_BITS = 8,
   parameter int PW            = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ntc_pkg::R_W-1:0]  in_x,
   input  logic [PW-1:0]         in_pl,
   output logic                  out_valid,
   output logic [ntc_pkg::LN_W-1:0] out_ln,
   output logic [PW-1:0]         out_pl
);
   import ntc_pkg::*;

   localparam int L     = $clog2(R_W);
   localparam int TB    = LN_TABLE_BITS;
   localparam int SH    = 32 - TB;
   localparam int NINT  = 1 << TB;
   localparam int LNT   = NINT + 1;
   localparam int IW    = $clog2(LNT);

   // ln(1+i/n) table
   logic [31:0] rom [LNT];
   for (genvar i = 0; i < LNT; i++) begin : g_rom
      localparam logic [63:0] Z = (64'(i) << 32) / 64'(2 * NINT + i);
      assign rom[i] = atanh_ln(Z);
   end

   // normalize stages
   logic [R_W-1:0] xn_ff [L];
   logic [L-1:0]   lz_ff [L];
   logic [PW-1:0]  npl_ff [L];
   logic           nv_ff [L];

   for (genvar j = 0; j < L; j++) begin : g_norm
      localparam int S = 1 << (L - 1 - j);
      logic [R_W-1:0] x_p;
      logic [L-1:0]   lz_p;
      logic [PW-1:0]  pl_p;
      logic           v_p;
      if (j == 0) begin : g_first
         assign x_p  = in_x;
         assign lz_p = '0;
         assign pl_p = in_pl;
         assign v_p  = in_valid;
      end else begin : g_next
         assign x_p  = xn_ff[j-1];
         assign lz_p = lz_ff[j-1];
         assign pl_p = npl_ff[j-1];
         assign v_p  = nv_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[j] <= 1'b0;
         end else begin
            nv_ff[j] <= v_p;
         end
         npl_ff[j] <= pl_p;
         if (x_p[R_W-1 -: S] == '0) begin
            xn_ff[j] <= x_p << S;
            lz_ff[j] <= lz_p | L'(S);
         end else begin
            xn_ff[j] <= x_p;
            lz_ff[j] <= lz_p;
         end
      end
   end

   // table lookup
   logic [31:0]   f32;
   logic [TB-1:0] idx;
   logic [IW-1:0] lo_idx;
   logic [IW-1:0] hi_idx;
   logic [31:0]   lo_ff;
   logic [31:0]   hi_ff;
   logic [SH-1:0] rem_ff;
   logic [L-1:0]  e_ff;
   logic [PW-1:0] tpl_ff;
   logic          tv_ff;

   always_comb begin
      f32    = xn_ff[L-1][R_W-2 -: 32];
      idx    = f32[31 -: TB];
      lo_idx = IW'(idx);
      hi_idx = IW'(idx) + IW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tv_ff <= 1'b0;
      end else begin
         tv_ff <= nv_ff[L-1];
      end
      lo_ff  <= rom[lo_idx];
      hi_ff  <= rom[hi_idx];
      rem_ff <= f32[SH-1:0];
      e_ff   <= L'(R_W - 1) - lz_ff[L-1];
      tpl_ff <= npl_ff[L-1];
   end

   // interpolation product and exponent term
   logic [31+SH:0]  prod_ff;
   logic [LN_W-1:0] base_ff;
   logic [PW-1:0]   mpl_ff;
   logic            mv_ff;
   logic [31:0]     slope;

   assign slope = hi_ff - lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
      end else begin
         mv_ff <= tv_ff;
      end
      prod_ff <= slope * rem_ff;
      base_ff <= LN_W'(e_ff) * LN_W'(LN2_Q32) + LN_W'(lo_ff);
      mpl_ff  <= tpl_ff;
   end

   // final sum
   logic [LN_W-1:0] ln_ff;
   logic [PW-1:0]   opl_ff;
   logic            ov_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else begin
         ov_ff <= mv_ff;
      end
      ln_ff  <= base_ff + LN_W'(prod_ff[31+SH:SH]);
      opl_ff <= mpl_ff;
   end

   assign out_valid = ov_ff;
   assign out_ln    = ln_ff;
   assign out_pl    = opl_ff;

endmodule

>>> rtl/ntc_thermistor_temperature.sv
// ---------------------------------------------------------------------------
// ntc_thermistor_temperature
// NTC thermistor resistance and Beta-equation temperature from a
// divider node voltage, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
//   An item is taken at a clock edge with start high and busy low. busy
//   stays low, so one node voltage may enter every cycle.
//   Each result appears for one cycle, with rsp_valid high. Results leave in
//   input order; the receiver cannot stall and the pipeline never holds.
//   The pipeline holds three bit-per-stage dividers (resistance 46 stages,
//   beta term 48 stages, temperature 49 stages), the log unit (9 stages)
//   and the glue stages between them.
//   Registers are written over the csr_ channel (always ready); the user
//   must write them only while no item is in flight, as the block does not
//   enforce it; they take effect for items accepted afterward.
//   Reset is synchronous: it empties the pipeline and restores the
//   register defaults (3300 mV, 10 kohm, 3950 K, 10 kohm, 298.15 K).
// ---------------------------------------------------------------------------
module ntc_thermistor_temperature #(
   parameter int LN_TABLE_BITS = ntc_pkg::LN_TABLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [12:0]        req_node_mv,
   output logic               rsp_valid,
   output logic [31:0]        rsp_ntc_ohm,
   output logic signed [18:0] rsp_temp_centi_c,
   output logic               rsp_clamped,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_data
);
   import ntc_pkg::*;

   // configuration registers
   logic [12:0] supply_ff;
   logic [19:0] series_ff;
   logic [13:0] beta_ff;
   logic [19:0] rref_ff;
   logic [15:0] t0_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         supply_ff <= SUPPLY_RST;
         series_ff <= SERIES_RST;
         beta_ff   <= BETA_RST;
         rref_ff   <= RREF_RST;
         t0_ff     <= T0_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SUPPLY: supply_ff <= csr_data[12:0];
            CSR_SERIES: series_ff <= csr_data;
            CSR_BETA:   beta_ff   <= csr_data[13:0];
            CSR_RREF:   rref_ff   <= csr_data;
            CSR_T0:     t0_ff     <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // input register
   logic        s0_v_ff;
   logic [12:0] s0_node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else begin
         s0_v_ff <= start && !busy;
      end
      s0_node_ff <= req_node_mv;
   end

   // voltage clamp
   logic [16:0] s10;
   logic [16:0] vtop;
   logic [16:0] v10_in;
   logic        cl_in;
   logic [16:0] s1_v10_ff;
   logic [16:0] s1_d_ff;
   logic        s1_cl_ff;
   logic        s1_zero_ff;
   logic        s1_v_ff;

   always_comb begin
      s10    = 17'(supply_ff) * 17'd10;
      vtop   = s10 - 17'd1;
      v10_in = 17'(s0_node_ff) * 17'd10;
      cl_in  = 1'b0;
      if (s0_node_ff == '0) begin
         v10_in = 17'd1;
         cl_in  = 1'b1;
      end
      if (v10_in >= vtop) begin
         v10_in = vtop;
         cl_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s0_v_ff;
      end
      s1_v10_ff  <= v10_in;
      s1_d_ff    <= s10 - v10_in;
      s1_cl_ff   <= cl_in;
      s1_zero_ff <= (supply_ff == '0);
   end

   // series resistor times voltage
   logic [36:0] s2_prod_ff;
   logic [16:0] s2_d_ff;
   logic        s2_cl_ff;
   logic        s2_zero_ff;
   logic        s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s1_v_ff;
      end
      s2_prod_ff <= 37'(series_ff) * 37'(s1_v10_ff);
      s2_d_ff    <= s1_d_ff;
      s2_cl_ff   <= s1_cl_ff;
      s2_zero_ff <= s1_zero_ff;
   end

   // resistance divider operands, rounded numerator
   logic [R_W-1:0] s3_num_ff;
   logic [16:0]    s3_den_ff;
   logic           s3_cl_ff;
   logic           s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s2_v_ff;
      end
      s3_cl_ff <= s2_cl_ff;
      if (s2_zero_ff) begin
         s3_num_ff <= '0;
         s3_den_ff <= 17'd1;
      end else begin
         s3_num_ff <= R_W'({s2_prod_ff, 8'b0}) + R_W'(s2_d_ff >> 1);
         s3_den_ff <= s2_d_ff;
      end
   end

   logic           dr_v;
   logic [R_W-1:0] dr_q;
   logic           dr_cl;

   ntc_div #(.N(R_W), .D(17), .PW(1)) u_div_r (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s3_v_ff),
      .in_num   (s3_num_ff),
      .in_den   (s3_den_ff),
      .in_pl    (s3_cl_ff),
      .out_valid(dr_v),
      .out_quo  (dr_q),
      .out_pl   (dr_cl)
   );

   // resistance floor and whole-ohm rounding
   logic           floor_hit;
   logic [R_W-1:0] rr;
   logic [R_W:0]   rsum;
   logic [R_W-1:0] f_r_ff;
   logic [31:0]    f_ohm_ff;
   logic           f_cl_ff;
   logic           f_v_ff;

   always_comb begin
      floor_hit = (dr_q < R_W'(256));
      rr        = floor_hit ? R_W'(256) : dr_q;
      rsum      = (R_W+1)'(rr) + (R_W+1)'(128);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= 1'b0;
      end else begin
         f_v_ff <= dr_v;
      end
      f_r_ff  <= rr;
      f_cl_ff <= dr_cl | floor_hit;
      if (rsum[R_W:40] != '0) begin
         f_ohm_ff <= 32'hFFFF_FFFF;
      end else begin
         f_ohm_ff <= rsum[39:8];
      end
   end

   // logs of resistance and reference
   logic [19:0]     rref_nz;
   logic [R_W-1:0]  ref_x;
   logic            la_v;
   logic [LN_W-1:0] la_ln;
   logic [31:0]     la_ohm;
   logic [LN_W-1:0] lb_ln;
   logic            lb_cl;

   assign rref_nz = (rref_ff == '0) ? 20'd1 : rref_ff;
   assign ref_x   = R_W'({rref_nz, 8'b0});

   ntc_ln #(.LN_TABLE_BITS(LN_TABLE_BITS), .PW(32)) u_ln_r (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_v_ff),
      .in_x     (f_r_ff),
      .in_pl    (f_ohm_ff),
      .out_valid(la_v),
      .out_ln   (la_ln),
      .out_pl   (la_ohm)
   );

   ntc_ln #(.LN_TABLE_BITS(LN_TABLE_BITS), .PW(1)) u_ln_ref (
      .clock    (clock),
      .reset    (reset),
      .in_valid (f_v_ff),
      .in_x     (ref_x),
      .in_pl    (f_cl_ff),
      .out_valid(),
      .out_ln   (lb_ln),
      .out_pl   (lb_cl)
   );

   // log ratio
   logic [LN_W:0] g_diff_ff;
   logic [31:0]   g_ohm_ff;
   logic          g_cl_ff;
   logic          g_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else begin
         g_v_ff <= la_v;
      end
      g_diff_ff <= {1'b0, la_ln} - {1'b0, lb_ln};
      g_ohm_ff  <= la_ohm;
      g_cl_ff   <= lb_cl;
   end

   // magnitude and divider operands for the beta term and 1/T0
   logic            neg;
   logic [LN_W:0]   diff_neg;
   logic [LN_W-1:0] mag;
   logic [13:0]     beta_nz;
   logic [15:0]     t0_nz;
   logic [Q_W-1:0]  h_numb_ff;
   logic [Q_W-1:0]  h_numa_ff;
   logic [13:0]     h_beta_ff;
   logic [15:0]     h_t0_ff;
   logic [32:0]     h_pl_ff;
   logic            h_neg_ff;
   logic            h_v_ff;

   always_comb begin
      neg      = g_diff_ff[LN_W];
      diff_neg = -g_diff_ff;
      mag      = neg ? diff_neg[LN_W-1:0] : g_diff_ff[LN_W-1:0];
      beta_nz  = (beta_ff == '0) ? 14'd1 : beta_ff;
      t0_nz    = (t0_ff == '0) ? 16'd1 : t0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_v_ff <= 1'b0;
      end else begin
         h_v_ff <= g_v_ff;
      end
      h_numb_ff <= Q_W'({mag, 8'b0}) + Q_W'(beta_nz >> 1);
      h_numa_ff <= INV_NUM + Q_W'(t0_nz >> 1);
      h_beta_ff <= beta_nz;
      h_t0_ff   <= t0_nz;
      h_pl_ff   <= {g_ohm_ff, g_cl_ff};
      h_neg_ff  <= neg;
   end

   logic           db_v;
   logic [Q_W-1:0] db_q;
   logic [32:0]    db_pl;
   logic [Q_W-1:0] da_q;
   logic           da_neg;

   ntc_div #(.N(Q_W), .D(14), .PW(33)) u_div_b (
      .clock    (clock),
      .reset    (reset),
      .in_valid (h_v_ff),
      .in_num   (h_numb_ff),
      .in_den   (h_beta_ff),
      .in_pl    (h_pl_ff),
      .out_valid(db_v),
      .out_quo  (db_q),
      .out_pl   (db_pl)
   );

   ntc_div #(.N(Q_W), .D(16), .PW(1)) u_div_a (
      .clock    (clock),
      .reset    (reset),
      .in_valid (h_v_ff),
      .in_num   (h_numa_ff),
      .in_den   (h_t0_ff),
      .in_pl    (h_neg_ff),
      .out_valid(),
      .out_quo  (da_q),
      .out_pl   (da_neg)
   );

   // reciprocal temperature
   logic [T_W-1:0] bpos;
   logic [T_W-1:0] bsig;
   logic [T_W-1:0] i_inv_ff;
   logic [32:0]    i_pl_ff;
   logic           i_v_ff;

   always_comb begin
      bpos = T_W'(db_q);
      bsig = da_neg ? -bpos : bpos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_v_ff <= 1'b0;
      end else begin
         i_v_ff <= db_v;
      end
      i_inv_ff <= T_W'(da_q) + bsig;
      i_pl_ff  <= db_pl;
   end

   // temperature divider operands
   logic           nonpos;
   logic [T_W-1:0] j_num_ff;
   logic [T_W-2:0] j_den_ff;
   logic [33:0]    j_pl_ff;
   logic           j_v_ff;

   assign nonpos = i_inv_ff[T_W-1] || (i_inv_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         j_v_ff <= 1'b0;
      end else begin
         j_v_ff <= i_v_ff;
      end
      j_pl_ff <= {i_pl_ff, nonpos};
      if (nonpos) begin
         j_num_ff <= '0;
         j_den_ff <= (T_W-1)'(1);
      end else begin
         j_num_ff <= T_W'(INV_NUM) + T_W'(i_inv_ff[T_W-2:1]);
         j_den_ff <= i_inv_ff[T_W-2:0];
      end
   end

   logic           dt_v;
   logic [T_W-1:0] dt_q;
   logic [33:0]    dt_pl;

   ntc_div #(.N(T_W), .D(T_W-1), .PW(34)) u_div_t (
      .clock    (clock),
      .reset    (reset),
      .in_valid (j_v_ff),
      .in_num   (j_num_ff),
      .in_den   (j_den_ff),
      .in_pl    (j_pl_ff),
      .out_valid(dt_v),
      .out_quo  (dt_q),
      .out_pl   (dt_pl)
   );

   // celsius conversion, saturation and result register
   logic        k_v_ff;
   logic [31:0] k_ohm_ff;
   logic [18:0] k_temp_ff;
   logic        k_cl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
      end else begin
         k_v_ff <= dt_v;
      end
      k_ohm_ff <= dt_pl[33:2];
      k_cl_ff  <= dt_pl[1];
      if (dt_pl[0] || (dt_q > TC_MAX)) begin
         k_temp_ff <= TEMP_MAX;
      end else begin
         k_temp_ff <= dt_q[18:0] - KELVIN_OFS;
      end
   end

   assign rsp_valid        = k_v_ff;
   assign rsp_ntc_ohm      = k_ohm_ff;
   assign rsp_temp_centi_c = $signed(k_temp_ff);
   assign rsp_clamped      = k_cl_ff;

endmodule

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives node voltages into the thermistor temperature pipeline under
// several register settings and checks each result against a bit-exact
// integer prediction of resistance, Beta-equation temperature and clamp flag.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import ntc_pkg::*;

   localparam int WATCH_LIMIT = 20000;
   localparam int TAIL_CYCLES = 200;

   typedef struct {
      logic [31:0]        ohm;
      logic signed [18:0] temp;
      logic               clamp;
   } ntc_result_type;

   // prediction of the block and store of expected readings
   class ntc_scoreboard;
      longint unsigned    ln_rom[];
      longint unsigned    supply, series, beta, rref, t0;
      ntc_result_type     pending[$];
      int                 errors;

      function new();
         longint unsigned n, z, z2, term, sum;
         n = 64'd1 << LN_TABLE_BITS_DEF;
         ln_rom = new[n + 1];
         for (longint unsigned i = 0; i <= n; i++) begin
            z = (i << 32) / (2 * n + i);
            z2 = (z * z) >> 32;
            term = z;
            sum = 0;
            for (int k = 0; k < 20; k++) begin
               sum += term / (2 * k + 1);
               term = (term * z2) >> 32;
            end
            ln_rom[i] = (2 * sum) & 64'hFFFF_FFFF;
         end
         supply = SUPPLY_RST; series = SERIES_RST; beta = BETA_RST;
         rref = RREF_RST; t0 = T0_RST;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [19:0] val);
         case (idx)
            CSR_SUPPLY: supply = val[12:0];
            CSR_SERIES: series = val;
            CSR_BETA:   beta   = val[13:0];
            CSR_RREF:   rref   = val;
            CSR_T0:     t0     = val[15:0];
            default: ;
         endcase
      endfunction

      // natural log in Q32 by table and linear interpolation
      function longint log_q32(longint unsigned x);
         int unsigned     e, sh;
         longint unsigned f, idx, rem, lo, hi;
         e = 0;
         sh = 32 - LN_TABLE_BITS_DEF;
         if (x == 0) return 0;
         while (e < 63 && (x >> (e + 1)) != 0) e++;
         f = x - (64'd1 << e);
         if (e <= 32) f = f << (32 - e);
         else f = f >> (e - 32);
         idx = f >> sh;
         rem = f & ((64'd1 << sh) - 1);
         lo = ln_rom[idx];
         hi = ln_rom[idx + 1];
         return longint'(e * 64'd2977044472 + lo + (((hi - lo) * rem) >> sh));
      endfunction

      function void note_item(logic [12:0] node);
         longint unsigned r, ohm, bt, rr, tt, a, mag, bm, tc, top, v10, d;
         longint          lnr, b, inv, temp;
         ntc_result_type  res;
         res.clamp = 0;
         if (supply == 0) begin
            r = 0;
            res.clamp = 1;
         end else begin
            top = supply * 10 - 1;
            v10 = node * 10;
            if (node == 0) begin v10 = 1; res.clamp = 1; end
            if (v10 >= top) begin v10 = top; res.clamp = 1; end
            d = supply * 10 - v10;
            r = (series * v10 * 256 + d / 2) / d;
         end
         if (r < 256) begin r = 256; res.clamp = 1; end
         ohm = (r + 128) >> 8;
         if (ohm > 64'hFFFF_FFFF) ohm = 64'hFFFF_FFFF;
         bt = beta ? beta : 1;
         rr = rref ? rref : 1;
         tt = t0 ? t0 : 1;
         lnr = log_q32(r) - log_q32(rr * 256);
         mag = lnr < 0 ? -lnr : lnr;
         bm = (mag * 256 + bt / 2) / bt;
         b = lnr < 0 ? -longint'(bm) : longint'(bm);
         a = ((64'd100 << 40) + tt / 2) / tt;
         inv = longint'(a) + b;
         if (inv <= 0) temp = 200000;
         else begin
            tc = ((64'd100 << 40) + inv / 2) / inv;
            if (tc > 227315) temp = 200000;
            else temp = longint'(tc) - 27315;
         end
         res.ohm = ohm[31:0];
         res.temp = temp[18:0];
         pending.push_back(res);
      endfunction

      function void check_reading(logic [31:0] ohm, logic signed [18:0] temp, logic clamp);
         ntc_result_type exp_r;
         if (pending.size() == 0) begin
            $error("unexpected result ohm=%0d temp=%0d", ohm, temp);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (ohm !== exp_r.ohm) begin
            $error("ntc_ohm expected %0d actual %0d", exp_r.ohm, ohm);
            errors++;
         end
         if (temp !== exp_r.temp) begin
            $error("temp_centi_c expected %0d actual %0d", exp_r.temp, temp);
            errors++;
         end
         if (clamp !== exp_r.clamp) begin
            $error("clamped expected %0b actual %0b", exp_r.clamp, clamp);
            errors++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [12:0]        req_node_mv;
   logic               rsp_valid;
   logic [31:0]        rsp_ntc_ohm;
   logic signed [18:0] rsp_temp_centi_c;
   logic               rsp_clamped;
   logic               csr_valid;
   logic               csr_ready;
   logic [2:0]         csr_index;
   logic [19:0]        csr_data;

   logic               item_took;
   logic               csr_took;
   int                 quiet_cycles;
   ntc_scoreboard      sb;

   ntc_thermistor_temperature DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_node_mv(req_node_mv), .rsp_valid(rsp_valid),
      .rsp_ntc_ohm(rsp_ntc_ohm), .rsp_temp_centi_c(rsp_temp_centi_c),
      .rsp_clamped(rsp_clamped), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0; #6;
      clock = 1'b1; #6;
   end

   initial begin
      sb = new();
      item_took = 0;
      csr_took = 0;
      quiet_cycles = 0;
   end

   // sample handshakes and results at the rising edge
   always @(posedge clock) begin
      item_took <= !reset && start && !busy;
      csr_took <= !reset && csr_valid && csr_ready;
      if (!reset) begin
         if (start && !busy) sb.note_item(req_node_mv);
         if (csr_valid && csr_ready) sb.write_reg(csr_index_type'(csr_index), csr_data);
         if (rsp_valid) sb.check_reading(rsp_ntc_ohm, rsp_temp_centi_c, rsp_clamped);
      end
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // random idle gap, mostly short, sometimes long
   task automatic idle_gap();
      int n;
      if ($urandom_range(0, 2) == 0) n = 0;
      else if ($urandom_range(0, 19) == 0) n = $urandom_range(20, 200);
      else n = $urandom_range(1, 4);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // offer one item and hold it until taken
   task automatic send_item(logic [12:0] node);
      start <= 1'b1;
      req_node_mv <= node;
      do @(negedge clock); while (!item_took);
   endtask

   // one register write; the caller drops valid after the last one
   task automatic write_csr(csr_index_type idx, logic [19:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(negedge clock); while (!csr_took);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   logic [19:0] phase_cfg[12][5] = '{
      '{3300, 10000, 3950, 10000, 29815},
      '{1, 1, 1, 1, 1},
      '{8191, 1000000, 10000, 1000000, 40000},
      '{8191, 1, 10000, 1000000, 1},
      '{1, 1000000, 1, 1, 40000},
      '{0, 10000, 3950, 10000, 29815},
      '{5000, 0, 0, 0, 0},
      '{3300, 100000, 3435, 100000, 29815},
      '{5000, 4700, 3380, 4700, 27315},
      '{1200, 1000000, 10000, 1, 40000},
      '{8191, 22000, 4200, 47000, 32315},
      '{2500, 1000000, 1, 1000000, 1}
   };

   initial begin
      logic [12:0] node;
      int          supply;
      reset = 1'b1;
      start = 1'b0;
      req_node_mv = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SUPPLY;
      csr_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed and random voltages under each register setting
      foreach (phase_cfg[p]) begin
         if (p > 0) begin
            drain();
            for (int i = 0; i < 5; i++) write_csr(csr_index_type'(i), phase_cfg[p][i]);
            csr_valid <= 1'b0;
         end
         supply = phase_cfg[p][0];
         // edge voltages: zero, one, near supply, at supply, above supply, full scale, half supply and two bit patterns
         if (p == 0 || p == 2 || p == 5) begin
            send_item(0);
            send_item(1);
            send_item(13'(supply > 0 ? supply - 1 : 0));
            send_item(13'(supply));
            send_item(13'(supply + 1));
            send_item(13'h1FFF);
            send_item(13'(supply / 2));
            send_item(13'h0AAA);
            send_item(13'h1555);
         end
         // random voltages, mostly within the supply
         for (int k = 0; k < 130; k++) begin
            idle_gap();
            if ($urandom_range(0, 4) == 0 || supply < 2) node = 13'($urandom);
            else node = 13'($urandom_range(0, supply));
            send_item(node);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
